// ===== src/stoi_pkg.sv =====
// stoi_pkg: shared types and constants for the string to integer converter
// depends on nothing; imported by every module of the block
package stoi_pkg;

	// fixed field widths
	localparam int CHAR_W  = 8;
	localparam int LEN_W   = 5;
	localparam int IDX_W   = 4;
	localparam int VAL_W   = 32;
	localparam int CFG_W   = 64;
	localparam int CIDX_W  = 2;
	localparam int ALPHA_N = 16;

	// default alphabet size limit
	localparam int MAX_LEN_DEF = 16;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] REG_BASE_LENGTH = 2'd0;
	localparam logic [CIDX_W-1:0] REG_CHARS_LOW   = 2'd1;
	localparam logic [CIDX_W-1:0] REG_CHARS_HIGH  = 2'd2;

	// configuration reset values: "0123456789"
	localparam logic [LEN_W-1:0] RST_BASE_LENGTH = 5'd10;
	localparam logic [CFG_W-1:0] RST_CHARS_LOW   = 64'h3736_3534_3332_3130;
	localparam logic [CFG_W-1:0] RST_CHARS_HIGH  = 64'h0000_0000_0000_3938;

	// character codes
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

	// parse phase
	typedef enum logic [1:0] {
		PH_BLANK = 2'd0,
		PH_SIGN  = 2'd1,
		PH_DIGIT = 2'd2,
		PH_DONE  = 2'd3
	} phase_t;

	// alphabet lookup result for one character
	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] index;
	} lookup_t;

endpackage

// ===== src/stoi_alphabet.sv =====
// stoi_alphabet: parallel digit lookup and alphabet validity check
// depends on stoi_pkg
module stoi_alphabet
	import stoi_pkg::*;
#(
	parameter int MAX_BASE_LENGTH = MAX_LEN_DEF
) (
	input  logic [LEN_W-1:0]  base_length,
	input  logic [CFG_W-1:0]  base_chars_low,
	input  logic [CFG_W-1:0]  base_chars_high,
	input  logic [CHAR_W-1:0] character,
	output lookup_t           lookup,
	output logic [LEN_W-1:0]  used_len,
	output logic              base_ok
);

	logic [CHAR_W-1:0] alpha [ALPHA_N];
	logic              dup;
	logic              bad_char;

	// unpack the alphabet bytes
	always_comb begin
		for (int i = 0; i < ALPHA_N / 2; i++) begin
			alpha[i]               = base_chars_low[i*CHAR_W +: CHAR_W];
			alpha[i + ALPHA_N / 2] = base_chars_high[i*CHAR_W +: CHAR_W];
		end
	end

	// length in use, clipped to the limit
	always_comb begin
		if (base_length > LEN_W'(MAX_BASE_LENGTH)) begin
			used_len = LEN_W'(MAX_BASE_LENGTH);
		end else begin
			used_len = base_length;
		end
	end

	// digit match, lowest index wins
	always_comb begin
		lookup = '0;
		for (int i = MAX_BASE_LENGTH - 1; i >= 0; i--) begin
			if (LEN_W'(i) < used_len && alpha[i] == character) begin
				lookup.hit   = 1'b1;
				lookup.index = IDX_W'(i);
			end
		end
	end

	// duplicates and forbidden characters among those in use
	always_comb begin
		dup      = 1'b0;
		bad_char = 1'b0;
		for (int i = 0; i < MAX_BASE_LENGTH; i++) begin
			if (LEN_W'(i) < base_length) begin
				if (alpha[i] == CH_NUL || alpha[i] == CH_PLUS || alpha[i] == CH_MINUS) begin
					bad_char = 1'b1;
				end
				for (int j = i + 1; j < MAX_BASE_LENGTH; j++) begin
					if (LEN_W'(j) < base_length && alpha[i] == alpha[j]) begin
						dup = 1'b1;
					end
				end
			end
		end
	end

	assign base_ok = (base_length >= LEN_W'(2)) && (base_length <= LEN_W'(MAX_BASE_LENGTH))
		&& !dup && !bad_char;

endmodule

// ===== src/stoi_core.sv =====
// stoi_core: parse state (phase, sign, accumulator) and result value
// depends on stoi_pkg; fed by stoi_alphabet
module stoi_core
	import stoi_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic [CHAR_W-1:0]       character,
	input  logic                    last,
	input  lookup_t                 lookup,
	input  logic [LEN_W-1:0]        used_len,
	input  logic                    base_ok,
	output logic signed [VAL_W-1:0] value,
	output logic                    base_error
);

	phase_t             phase_q, phase_d;
	logic               neg_q, neg_d;
	logic [VAL_W-1:0]   acc_q, acc_d;
	logic [VAL_W+LEN_W-1:0] prod;

	assign prod = acc_q * used_len;

	// blank, sign and digit phases in one pass
	always_comb begin
		phase_d = phase_q;
		neg_d   = neg_q;
		acc_d   = acc_q;
		if (phase_d == PH_BLANK) begin
			if (!(character inside {CH_SPACE, [CH_TAB:CH_CR]})) begin
				phase_d = PH_SIGN;
			end
		end
		if (phase_d == PH_SIGN) begin
			if (character == CH_MINUS) begin
				neg_d = ~neg_d;
			end else if (character != CH_PLUS) begin
				phase_d = PH_DIGIT;
			end
		end
		if (phase_d == PH_DIGIT) begin
			if (!lookup.hit) begin
				phase_d = PH_DONE;
			end else begin
				acc_d = prod[VAL_W-1:0] + VAL_W'(lookup.index);
			end
		end
	end

	// result for the last item
	always_comb begin
		base_error = !base_ok;
		if (!base_ok) begin
			value = '0;
		end else if (neg_d) begin
			value = signed'(VAL_W'(0) - acc_d);
		end else begin
			value = signed'(acc_d);
		end
	end

	// state register, cleared after the last item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BLANK;
			neg_q   <= 1'b0;
			acc_q   <= '0;
		end else if (en) begin
			if (last) begin
				phase_q <= PH_BLANK;
				neg_q   <= 1'b0;
				acc_q   <= '0;
			end else begin
				phase_q <= phase_d;
				neg_q   <= neg_d;
				acc_q   <= acc_d;
			end
		end
	end

endmodule

// ===== src/string_to_integer_any_base.sv =====
// string_to_integer_any_base: top level with config registers, input and result registers
// depends on stoi_pkg, stoi_alphabet, stoi_core
//
// Converts a string, one character per item, into a signed 32-bit value using a
// configurable alphabet of up to 16 digit characters (reset: decimal "0123456789").
// Input channel: in_valid / in_stall with character and last. Only the item marked
// last produces a result on the output channel (out_valid / out_stall) carrying
// value and base_error; base_error is set and value is 0 when the alphabet is invalid.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high; index 0 base_length, 1 base_chars_low, 2 base_chars_high.
// Items are taken one per cycle while in_stall is low. The item marked last sits in
// the input register, is parsed in one pass and then loads the result register, which
// drives the output port.
// When the receiver stalls, a held result blocks only a following last item;
// in_stall rises only while the result register is full and stalled.
// Reset (arst_n low, asynchronous) empties both registers, restarts parsing and
// loads the default alphabet.
module string_to_integer_any_base
	import stoi_pkg::*;
#(
	parameter int MAX_BASE_LENGTH = MAX_LEN_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [CHAR_W-1:0]       character,
	input  logic                    last,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [VAL_W-1:0] value,
	output logic                    base_error,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CIDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]        cfg_data
);

	logic [LEN_W-1:0]        base_length_q;
	logic [CFG_W-1:0]        chars_low_q;
	logic [CFG_W-1:0]        chars_high_q;
	logic                    valid_s1;
	logic [CHAR_W-1:0]       char_s1;
	logic                    last_s1;
	logic                    out_valid_s2;
	logic signed [VAL_W-1:0] value_s2;
	logic                    base_error_s2;
	logic                    advance;
	lookup_t                 lookup;
	logic [LEN_W-1:0]        used_len;
	logic                    base_ok;
	logic signed [VAL_W-1:0] res_value;
	logic                    res_error;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_length_q <= RST_BASE_LENGTH;
			chars_low_q   <= RST_CHARS_LOW;
			chars_high_q  <= RST_CHARS_HIGH;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BASE_LENGTH: base_length_q <= cfg_data[LEN_W-1:0];
				REG_CHARS_LOW:   chars_low_q   <= cfg_data;
				REG_CHARS_HIGH:  chars_high_q  <= cfg_data;
				default:         ;
			endcase
		end
	end

	// stage 1 moves on unless it holds a last item and the result register is blocked
	assign advance  = valid_s1 && (!last_s1 || !out_valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= character;
			last_s1 <= last;
		end
	end

	stoi_alphabet #(
		.MAX_BASE_LENGTH(MAX_BASE_LENGTH)
	) u_alphabet (
		.base_length    (base_length_q),
		.base_chars_low (chars_low_q),
		.base_chars_high(chars_high_q),
		.character      (char_s1),
		.lookup         (lookup),
		.used_len       (used_len),
		.base_ok        (base_ok)
	);

	stoi_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.character (char_s1),
		.last      (last_s1),
		.lookup    (lookup),
		.used_len  (used_len),
		.base_ok   (base_ok),
		.value     (res_value),
		.base_error(res_error)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			value_s2      <= res_value;
			base_error_s2 <= res_error;
		end
	end

	assign out_valid  = out_valid_s2;
	assign value      = value_s2;
	assign base_error = base_error_s2;

endmodule

// ===== src/stoi_checker.sv =====
// stoi_checker: port-level assertions for string_to_integer_any_base
// depends on stoi_pkg; attached to the top level by the bind below
module stoi_checker
	import stoi_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [VAL_W-1:0] value,
	input logic                    base_error
);

	// a stalled result stays
	ast_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its value
	ast_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(value) && $stable(base_error))
		else $error("result changed while stalled");

	// invalid alphabet gives zero
	ast_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && base_error |-> value == '0)
		else $error("nonzero value with base error");

	// input is held back only by a blocked result
	ast_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without blocked result");

endmodule

bind string_to_integer_any_base stoi_checker u_stoi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.value     (value),
	.base_error(base_error)
);

// ===== bench/string_to_integer_any_base_test.sv =====
// string_to_integer_any_base_test: self-checking bench for the string to integer converter
// drives strings one character per item, predicts each converted value and compares it
// depends on stoi_pkg and string_to_integer_any_base
`timescale 1ns / 100ps

module string_to_integer_any_base_test;
	import stoi_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_ITEMS  = 720;
	// index with no register behind it, writes there must be ignored
	localparam logic [CIDX_W-1:0] REG_UNMAPPED = 2'd3;

	typedef logic [CHAR_W-1:0] text_t[$];

	typedef struct {
		logic signed [VAL_W-1:0] value;
		logic                    base_error;
	} result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid;
	logic                    in_stall;
	logic [CHAR_W-1:0]       character;
	logic                    last;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic signed [VAL_W-1:0] value;
	logic                    base_error;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CIDX_W-1:0]       cfg_index;
	logic [CFG_W-1:0]        cfg_data;

	bit      steady;
	int      errors = 0;
	int      cycles = 0;
	int      items_sent;
	result_t expected_results[$];

	// predicted alphabet and parse state
	logic [LEN_W-1:0] alpha_len;
	logic [CFG_W-1:0] alpha_lo;
	logic [CFG_W-1:0] alpha_hi;
	phase_t           parse_phase;
	logic             negative;
	logic [VAL_W-1:0] accum;

	string_to_integer_any_base dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.character  (character),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.value      (value),
		.base_error (base_error),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #2 clk = ~clk;

	// alphabet helpers
	function automatic logic [CHAR_W-1:0] alpha_char(int i);
		return (i < 8) ? alpha_lo[8*i +: 8] : alpha_hi[8*(i-8) +: 8];
	endfunction

	function automatic int lookup_span();
		return (alpha_len > MAX_LEN_DEF) ? MAX_LEN_DEF : int'(alpha_len);
	endfunction

	function automatic bit alphabet_valid();
		int               n;
		logic [CHAR_W-1:0] c;
		if (alpha_len < 2 || alpha_len > MAX_LEN_DEF) return 1'b0;
		n = int'(alpha_len);
		for (int i = 0; i < n; i++) begin
			c = alpha_char(i);
			if (c == CH_NUL || c == CH_PLUS || c == CH_MINUS) return 1'b0;
			for (int j = i + 1; j < n; j++)
				if (alpha_char(j) == c) return 1'b0;
		end
		return 1'b1;
	endfunction

	// lowest matching index wins
	function automatic int digit_index(logic [CHAR_W-1:0] c);
		for (int i = 0; i < lookup_span(); i++)
			if (alpha_char(i) == c) return i;
		return -1;
	endfunction

	// advance the parse by one character, queue the value when the string ends
	function automatic void parse_char(logic [CHAR_W-1:0] c, logic l);
		int      d;
		result_t r;
		if (parse_phase == PH_BLANK && !(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)))
			parse_phase = PH_SIGN;
		if (parse_phase == PH_SIGN) begin
			if (c == CH_MINUS) negative = ~negative;
			else if (c != CH_PLUS) parse_phase = PH_DIGIT;
		end
		if (parse_phase == PH_DIGIT) begin
			d = digit_index(c);
			if (d < 0) parse_phase = PH_DONE;
			else accum = accum * 32'(lookup_span()) + 32'(d);
		end
		if (l) begin
			if (alphabet_valid()) begin
				r.value      = negative ? -accum : accum;
				r.base_error = 1'b0;
			end else begin
				r.value      = '0;
				r.base_error = 1'b1;
			end
			expected_results.push_back(r);
			parse_phase = PH_BLANK;
			negative    = 1'b0;
			accum       = '0;
		end
	endfunction

	function automatic void apply_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
		case (idx)
			REG_BASE_LENGTH: alpha_len = data[LEN_W-1:0];
			REG_CHARS_LOW:   alpha_lo = data;
			REG_CHARS_HIGH:  alpha_hi = data;
			default: ;
		endcase
	endfunction

	function automatic text_t ascii(string s);
		text_t t;
		foreach (s[i]) t.push_back(s[i]);
		return t;
	endfunction

	// random alphabet, mostly valid, sometimes broken in one way
	function automatic void random_alphabet(output logic [LEN_W-1:0] len,
			output logic [CFG_W-1:0] lo, output logic [CFG_W-1:0] hi);
		logic [CHAR_W-1:0] set[16];
		logic [CHAR_W-1:0] bad[3];
		logic [CHAR_W-1:0] c;
		bit                clash;
		int                n;
		int                a;
		bad = '{CH_NUL, CH_PLUS, CH_MINUS};
		for (int i = 0; i < 16; i++) begin
			do begin
				c = 8'($urandom_range(1, 255));
				clash = (c == CH_PLUS || c == CH_MINUS);
				for (int j = 0; j < i; j++)
					if (set[j] == c) clash = 1'b1;
			end while (clash);
			set[i] = c;
		end
		n = ($urandom_range(3) == 0) ? 16 : $urandom_range(2, 16);
		case ($urandom_range(9))
			0: n = $urandom_range(0, 1);
			1: n = $urandom_range(17, 31);
			2: begin
				a = $urandom_range(1, n - 1);
				set[a] = set[$urandom_range(0, a - 1)];
			end
			3: set[$urandom_range(0, n - 1)] = bad[$urandom_range(0, 2)];
			default: ;
		endcase
		for (int i = 0; i < 8; i++) begin
			lo[8*i +: 8] = set[i];
			hi[8*i +: 8] = set[i+8];
		end
		len = n[LEN_W-1:0];
	endfunction

	// mostly blanks, signs, digits and a tail; the rest plain noise
	function automatic text_t random_text();
		text_t s;
		int    span;
		int    k;
		span = lookup_span();
		if ($urandom_range(99) < 75) begin
			repeat ($urandom_range(0, 3)) begin
				k = $urandom_range(0, 5);
				s.push_back(k == 5 ? CH_SPACE : CH_TAB + 8'(k));
			end
			repeat ($urandom_range(0, 3)) s.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
			if (span > 0)
				repeat ($urandom_range(0, 12)) s.push_back(alpha_char($urandom_range(0, span - 1)));
			repeat ($urandom_range(0, 2)) s.push_back(8'($urandom));
		end else begin
			repeat ($urandom_range(1, 8)) s.push_back(8'($urandom));
		end
		if (s.size() == 0) s.push_back(8'($urandom));
		return s;
	endfunction

	// send one item, with random gaps before it outside the steady stretch
	task automatic send_item(logic [CHAR_W-1:0] c, logic l);
		while (!steady && $urandom_range(99) < 34) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		character <= c;
		last      <= l;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		parse_char(c, l);
		items_sent++;
	endtask

	task automatic send_text(text_t s);
		foreach (s[i]) send_item(s[i], i == s.size() - 1);
	endtask

	// stop sending and wait until every predicted value has come back
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// back to back register writes, unmapped index first
	task automatic configure(logic [LEN_W-1:0] len, logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi);
		logic [CIDX_W-1:0] idx[4];
		logic [CFG_W-1:0]  data[4];
		idx  = '{REG_UNMAPPED, REG_BASE_LENGTH, REG_CHARS_LOW, REG_CHARS_HIGH};
		data = '{{$urandom, $urandom}, {$urandom, 27'($urandom), len}, lo, hi};
		for (int k = 0; k < 4; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[k];
			cfg_data  <= data[k];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			apply_reg(idx[k], data[k]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic try_alphabet(logic [LEN_W-1:0] len, logic [CFG_W-1:0] lo,
			logic [CFG_W-1:0] hi, text_t s);
		settle();
		configure(len, lo, hi);
		send_text(s);
	endtask

	// decimal alphabet out of reset: blanks, sign runs, wrap, foreign characters
	task automatic test_decimal_default();
		send_text('{CH_SPACE, CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR,
			CH_MINUS, CH_MINUS, CH_PLUS, CH_MINUS, 8'h37});
		send_text(ascii("9999999999"));
		send_text('{8'h31, 8'hFF, 8'h35});
		send_text('{CH_NUL});
		send_text('{CH_PLUS});
	endtask

	// full hex, top-bit characters, lengths out of range, forbidden and repeated characters
	task automatic test_alphabet_limits();
		try_alphabet(5'd16, 64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938, ascii("-1f"));
		send_text(ascii("ffffffff1"));
		try_alphabet(5'd2, 64'h80FF, '0, '{8'hFF, 8'h80, 8'hFF});
		try_alphabet(5'd0, RST_CHARS_LOW, RST_CHARS_HIGH, ascii("12"));
		try_alphabet(5'd1, RST_CHARS_LOW, RST_CHARS_HIGH, ascii("12"));
		try_alphabet(5'd17, RST_CHARS_LOW, RST_CHARS_HIGH, ascii("12"));
		try_alphabet(5'd31, RST_CHARS_LOW, RST_CHARS_HIGH, ascii("12"));
		try_alphabet(5'd3, 64'h2B_3130, '0, ascii("1"));
		try_alphabet(5'd3, 64'h2D_3130, '0, ascii("1"));
		try_alphabet(5'd3, 64'h3130, '0, ascii("1"));
		try_alphabet(5'd4, 64'h3130_3130, '0, ascii("1"));
		try_alphabet(5'd16, '1, '1, '{8'hFF});
		try_alphabet(5'd2, '0, '0, '{CH_NUL});
	endtask

	// alphabet rewritten while a string is half parsed
	task automatic test_midstring_change();
		settle();
		configure(RST_BASE_LENGTH, RST_CHARS_LOW, RST_CHARS_HIGH);
		send_item(CH_MINUS, 1'b0);
		send_item(8'h31, 1'b0);
		send_item(8'h32, 1'b0);
		settle();
		configure(5'd2, 64'h3130, '0);
		send_item(8'h31, 1'b0);
		send_item(8'h30, 1'b1);
		send_item(8'h31, 1'b0);
		settle();
		// validity is judged on the last item
		configure(5'd1, 64'h3130, '0);
		send_item(8'h30, 1'b1);
	endtask

	// random strings over random alphabets, with a stretch of full rate
	task automatic test_random();
		int               start;
		int               strings;
		logic [LEN_W-1:0] len;
		logic [CFG_W-1:0] lo;
		logic [CFG_W-1:0] hi;
		start   = items_sent;
		strings = 0;
		while (items_sent < start + RANDOM_ITEMS) begin
			if (strings % 12 == 0) begin
				random_alphabet(len, lo, hi);
				settle();
				configure(len, lo, hi);
			end
			steady = (items_sent - start >= 300) && (items_sent - start < 450);
			send_text(random_text());
			strings++;
		end
		steady = 1'b0;
	endtask

	function automatic void check_result();
		result_t want;
		if (expected_results.size() == 0) begin
			$error("unexpected result: value %0d base_error %0b", value, base_error);
			errors++;
			return;
		end
		want = expected_results.pop_front();
		if (value !== want.value) begin
			$error("value: expected %0d, got %0d", want.value, value);
			errors++;
		end
		if (base_error !== want.base_error) begin
			$error("base_error: expected %0b, got %0b", want.base_error, base_error);
			errors++;
		end
	endfunction

	// result side: check accepted items, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) check_result();
			out_stall <= !steady && ($urandom_range(99) < 34);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		in_valid    <= 1'b0;
		character   <= '0;
		last        <= 1'b0;
		cfg_valid   <= 1'b0;
		cfg_index   <= '0;
		cfg_data    <= '0;
		steady      = 1'b0;
		items_sent  = 0;
		alpha_len   = RST_BASE_LENGTH;
		alpha_lo    = RST_CHARS_LOW;
		alpha_hi    = RST_CHARS_HIGH;
		parse_phase = PH_BLANK;
		negative    = 1'b0;
		accum       = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_decimal_default();
		test_alphabet_limits();
		test_midstring_change();
		test_random();
		settle();

		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
